>>> src/rom_dma_table_locator_core_assert.svh
// Assertion macros shared by the locator RTL. Each macro samples on the rising
// edge of clock and is disabled while reset is high.
`ifndef ROM_DMA_TABLE_LOCATOR_CORE_ASSERT_SVH
`define ROM_DMA_TABLE_LOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RDTL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define RDTL_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define RDTL_ASSERT(lbl, prop, msg)
`define RDTL_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

>>> src/rdtl_pkg.sv
`default_nettype none

package rdtl_pkg;

   localparam int WORD_W       = 32;
   localparam int COUNT_W      = 28;
   localparam int WINDOW_WORDS = 12;
   localparam int ENTRY_SHIFT  = 4;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [WORD_W-1:0] ROM_SIZE_RESET = 32'd67108864;

   // Register indexes, taken from byte address bit 2.
   localparam logic REG_ROM_SIZE = 1'b0;

   // Element 0 is the oldest word, element 11 the newest.
   typedef logic [WINDOW_WORDS-1:0][WORD_W-1:0] window_type;

   typedef struct packed {
      logic                found;
      logic [WORD_W-1:0]   table_offset;
      logic [WORD_W-1:0]   table_size;
      logic [COUNT_W-1:0]  entry_count;
   } result_type;

   typedef struct packed {
      logic                hit;
      logic [WORD_W-1:0]   table_offset;
      logic [WORD_W-1:0]   table_size;
   } check_type;

endpackage

`default_nettype wire

>>> src/rdtl_window.sv
`default_nettype none

module rdtl_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift_en,
   input  wire logic                          clear,
   input  wire logic [rdtl_pkg::WORD_W-1:0]   word,
   output rdtl_pkg::window_type               window,
   output logic      [rdtl_pkg::WORD_W-1:0]   word_index
);

   rdtl_pkg::window_type               window_ff;
   rdtl_pkg::window_type               window_in;
   logic [rdtl_pkg::WORD_W-1:0]        word_index_ff;
   logic [rdtl_pkg::WORD_W-1:0]        word_index_in;

   always_comb begin
      window_in     = window_ff;
      word_index_in = word_index_ff;
      if (shift_en) begin
         window_in = {word, window_ff[rdtl_pkg::WINDOW_WORDS-1:1]};
         if (clear) begin
            word_index_in = '0;
         end else begin
            word_index_in = word_index_ff + 32'd1;
         end
      end
   end

   // The window needs no reset: a candidate is only examined once twelve
   // words have arrived since the last clear.
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff <= '0;
      end else begin
         word_index_ff <= word_index_in;
      end
   end

   assign window     = window_ff;
   assign word_index = word_index_ff;

endmodule

`default_nettype wire

>>> src/rdtl_check.sv
`default_nettype none

module rdtl_check (
   input  wire rdtl_pkg::window_type          window,
   input  wire logic [rdtl_pkg::WORD_W-1:0]   word,
   input  wire logic [rdtl_pkg::WORD_W-1:0]   word_index,
   input  wire logic [rdtl_pkg::WORD_W-1:0]   size_limit,
   output rdtl_pkg::check_type                check
);

   rdtl_pkg::window_type            w;
   logic [rdtl_pkg::WORD_W-1:0]     cand_words;
   logic [rdtl_pkg::WORD_W+1:0]     cand_pos;
   logic [rdtl_pkg::WORD_W-1:0]     span;
   logic                            window_full;
   logic                            on_boundary;
   logic                            first_ok;
   logic                            second_ok;
   logic                            third_ok;
   logic                            ordered;
   logic                            within_rom;
   logic                            nonempty;
   logic                            at_candidate;

   always_comb begin
      // The check looks at the window as it stands after this word shifts in.
      w           = {word, window[rdtl_pkg::WINDOW_WORDS-1:1]};
      window_full = word_index >= 32'(rdtl_pkg::WINDOW_WORDS - 1);
      on_boundary = word_index[1:0] == 2'b11;
      cand_words  = word_index - 32'(rdtl_pkg::WINDOW_WORDS - 1);
      cand_pos    = {cand_words, 2'b00};
      span        = w[9] - w[8];

      first_ok  = (w[0] == '0) && (w[1] != '0) && (w[2] == '0) && (w[3] == '0);
      second_ok = (w[4] == w[1]) && (w[6] == w[1]) && (w[7] == '0);
      third_ok  = (w[8] == w[5]) && (w[10] == w[5]) && (w[11] == '0);
      ordered      = w[5] >= w[4];
      within_rom   = w[9] <= size_limit;
      nonempty     = w[9] > w[8];
      at_candidate = {2'b00, w[8]} == cand_pos;

      check.hit = window_full && on_boundary && first_ok && second_ok && third_ok &&
                  ordered && within_rom && nonempty && at_candidate &&
                  (span[rdtl_pkg::ENTRY_SHIFT-1:0] == '0);
      check.table_offset = w[8];
      check.table_size   = span;
   end

endmodule

`default_nettype wire

>>> src/rdtl_out.sv
`default_nettype none

module rdtl_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire rdtl_pkg::result_type result,
   input  wire logic              out_ready,
   output logic                   out_valid,
   output logic                   slot_free,
   output rdtl_pkg::result_type   out_result
);

   logic                   valid_ff;
   logic                   valid_in;
   rdtl_pkg::result_type   result_ff;
   rdtl_pkg::result_type   result_in;

   // The slot takes a new result in the same cycle that the old one leaves.
   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff && !out_ready;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

>>> src/rom_dma_table_locator_core.sv
`default_nettype none

`include "rom_dma_table_locator_core_assert.svh"

// Streaming locator for a three-entry file table in a ROM image. Words of the
// image arrive on req_ one per transfer, big-endian assembled, with req_tlast on
// the final word. The block takes one word every cycle; each word is checked
// against a twelve-word shift window in the cycle it is accepted, and a result
// shows on rsp_ in the next cycle from a single output register, which frees in
// the cycle its transfer completes, so the input keeps flowing while the
// consumer is ready. The first matching table gives one result with rsp_tuser
// high; an image without one gives a single result with rsp_tuser low on its
// last word. The rom_size_bytes register sits at csr_ address 0 and should be
// written only while the stream is idle.

module rom_dma_table_locator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: rom_word[31:0]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [31:0]                       req_tdata,
   input  wire logic                              req_tlast,
   // tdata: table_offset[31:0], table_size[63:32], entry_count[91:64], zero pad
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [95:0]                            rsp_tdata,
   // tuser: found[0]
   output logic                                   rsp_tuser,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rdtl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   logic [rdtl_pkg::WORD_W-1:0]  rom_limit_ff;
   logic [rdtl_pkg::WORD_W-1:0]  rom_limit_in;
   logic                         match_ff;
   logic                         match_in;
   logic                         req_accept;
   logic                         slot_free;
   logic                         hit;
   logic                         load;
   rdtl_pkg::window_type         window;
   logic [rdtl_pkg::WORD_W-1:0]  word_index;
   rdtl_pkg::check_type          check;
   rdtl_pkg::result_type         result;
   rdtl_pkg::result_type         out_result;

   // Configuration port.
   assign csr_pready = 1'b1;

   always_comb begin
      rom_limit_in = rom_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == rdtl_pkg::REG_ROM_SIZE)) begin
         rom_limit_in = csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == rdtl_pkg::REG_ROM_SIZE) begin
         csr_prdata = rom_limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_limit_ff <= rdtl_pkg::ROM_SIZE_RESET;
      end else begin
         rom_limit_ff <= rom_limit_in;
      end
   end

   // Datapath.
   assign req_tready = slot_free;
   assign req_accept = req_tvalid && req_tready;

   rdtl_window u_window (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (req_accept),
      .clear      (req_tlast),
      .word       (req_tdata),
      .window     (window),
      .word_index (word_index)
   );

   rdtl_check u_check (
      .window     (window),
      .word       (req_tdata),
      .word_index (word_index),
      .size_limit (rom_limit_ff),
      .check      (check)
   );

   assign hit  = req_accept && !match_ff && check.hit;
   assign load = hit || (req_accept && req_tlast && !match_ff);

   always_comb begin
      result = '0;
      if (hit) begin
         result.found        = 1'b1;
         result.table_offset = check.table_offset;
         result.table_size   = check.table_size;
         result.entry_count  =
            check.table_size[rdtl_pkg::WORD_W-1:rdtl_pkg::ENTRY_SHIFT];
      end
   end

   always_comb begin
      match_in = match_ff;
      if (req_accept) begin
         if (req_tlast) begin
            match_in = 1'b0;
         end else if (hit) begin
            match_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   rdtl_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .slot_free  (slot_free),
      .out_result (out_result)
   );

   assign rsp_tuser = out_result.found;
   assign rsp_tdata = {4'b0000, out_result.entry_count, out_result.table_size,
                       out_result.table_offset};

   // Checks.
   `RDTL_ASSERT(a_found_shape, rsp_tvalid && rsp_tuser |-> (rsp_tdata[35:32] == 4'b0000) && (rsp_tdata[63:32] != '0) && (rsp_tdata[91:64] == rsp_tdata[63:36]), "found result with inconsistent size")
   `RDTL_ASSERT(a_notfound_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "not-found result carries data")
   `RDTL_ASSERT_NEXT(a_last_clears, req_accept && req_tlast, (word_index == '0) && !match_ff, "state not cleared after last word")
   `RDTL_ASSERT_NEXT(a_hit_sets_flag, hit && !req_tlast, match_ff && rsp_tvalid && rsp_tuser, "reported match not recorded")

endmodule

`default_nettype wire

>>> bench/rom_dma_table_locator_checker.sv
`timescale 1ns / 1ps

module rom_dma_table_locator_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // tdata: rom_word[31:0]
   input  wire logic [31:0]                       req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: table_offset[31:0], table_size[63:32], entry_count[91:64], zero pad
   input  wire logic [95:0]                       rsp_tdata,
   // tuser: found[0]
   input  wire logic                              rsp_tuser,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rdtl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   input  wire logic [31:0]                       csr_prdata,
   input  wire logic                              csr_pready,
   output int unsigned                            fail_count,
   output int unsigned                            pending,
   output int unsigned                            words_seen,
   output int unsigned                            images_seen,
   output int unsigned                            tables_found,
   output int unsigned                            tables_missing
);

   localparam int unsigned PRINT_CAP = 40;

   logic [31:0]           rom_limit;
   logic [31:0]           window [rdtl_pkg::WINDOW_WORDS];
   logic [31:0]           words_in_image;
   bit                    table_reported;
   rdtl_pkg::result_type  expected_reports [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PRINT_CAP) begin
         $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
      end
      fail_count++;
   endtask

   task automatic restart_image();
      int k;
      for (k = 0; k < rdtl_pkg::WINDOW_WORDS; k++) window[k] = '0;
      words_in_image = '0;
      table_reported = 1'b0;
   endtask

   // The window holds three entries E0, E1, E2 that begin at byte offset cand.
   function automatic bit chain_ok(input logic [63:0] cand);
      bit          first_ok;
      bit          second_ok;
      bit          third_ok;
      logic [31:0] span;
      first_ok  = window[0] == 0 && window[1] != 0 && window[2] == 0 && window[3] == 0;
      second_ok = window[4] == window[1] && window[6] == window[1] && window[7] == 0;
      third_ok  = window[8] == window[5] && window[10] == window[5] && window[11] == 0;
      span      = window[9] - window[8];
      return first_ok && second_ok && third_ok && window[5] >= window[4]
         && window[9] <= rom_limit && window[9] > window[8]
         && {32'd0, window[8]} == cand && span[rdtl_pkg::ENTRY_SHIFT-1:0] == '0;
   endfunction

   task automatic track_rom_word(input logic [31:0] word, input logic is_last);
      logic [31:0]          idx;
      logic [63:0]          cand;
      logic [31:0]          span;
      rdtl_pkg::result_type res;
      int                   k;
      idx = words_in_image;
      for (k = 0; k < rdtl_pkg::WINDOW_WORDS - 1; k++) window[k] = window[k+1];
      window[rdtl_pkg::WINDOW_WORDS-1] = word;
      words_in_image = idx + 1;
      words_seen++;
      // A candidate is complete when its twelfth word lands on an entry boundary.
      if (!table_reported && idx >= rdtl_pkg::WINDOW_WORDS - 1 && idx[1:0] == 2'b11) begin
         cand = ({32'd0, idx} - (rdtl_pkg::WINDOW_WORDS - 1)) * 64'd4;
         if (chain_ok(cand)) begin
            span             = window[9] - window[8];
            res.found        = 1'b1;
            res.table_offset = window[8];
            res.table_size   = span;
            res.entry_count  = span[31:rdtl_pkg::ENTRY_SHIFT];
            expected_reports.push_back(res);
            table_reported = 1'b1;
         end
      end
      if (is_last) begin
         if (!table_reported) begin
            res = '0;
            expected_reports.push_back(res);
         end
         images_seen++;
         restart_image();
      end
   endtask

   task automatic check_report();
      rdtl_pkg::result_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("result with none expected, offset", rsp_tdata[31:0], '0);
      end else begin
         want = expected_reports.pop_front();
         if (rsp_tuser !== want.found)
            report_mismatch("found", {31'd0, rsp_tuser}, {31'd0, want.found});
         if (rsp_tdata[31:0] !== want.table_offset)
            report_mismatch("table_offset", rsp_tdata[31:0], want.table_offset);
         if (rsp_tdata[63:32] !== want.table_size)
            report_mismatch("table_size", rsp_tdata[63:32], want.table_size);
         if (rsp_tdata[91:64] !== want.entry_count)
            report_mismatch("entry_count", {4'd0, rsp_tdata[91:64]}, {4'd0, want.entry_count});
         if (rsp_tdata[95:92] !== 4'd0)
            report_mismatch("tdata pad", {28'd0, rsp_tdata[95:92]}, '0);
         if (want.found) tables_found++;
         else tables_missing++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rom_limit = rdtl_pkg::ROM_SIZE_RESET;
         expected_reports.delete();
         restart_image();
         fail_count     = 0;
         words_seen     = 0;
         images_seen    = 0;
         tables_found   = 0;
         tables_missing = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == rdtl_pkg::REG_ROM_SIZE)
         begin
            if (csr_pwrite) rom_limit = csr_pwdata;
            else if (csr_prdata !== rom_limit)
               report_mismatch("rom_size_bytes read", csr_prdata, rom_limit);
         end
         // Results are registered and never leave in the cycle of their word, so the oldest goes first.
         if (rsp_tvalid && rsp_tready) check_report();
         if (req_tvalid && req_tready) track_rom_word(req_tdata, req_tlast);
      end
      pending <= expected_reports.size();
   end

endmodule

>>> bench/tb_rom_dma_table_locator_core.sv
`timescale 1ns / 1ps

module tb_rom_dma_table_locator_core;

   localparam logic [2:0]  ROM_SIZE_ADDR = {rdtl_pkg::REG_ROM_SIZE, 2'b00};
   localparam logic [2:0]  SPARE_ADDR    = {~rdtl_pkg::REG_ROM_SIZE, 2'b00};
   localparam int unsigned PHASES        = 6;
   localparam int unsigned PHASE_WORDS   = 313;
   localparam int unsigned STALL_CYCLES  = 400;
   localparam int unsigned QUIET_LIMIT   = 3000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned words_seen;
   int unsigned images_seen;
   int unsigned tables_found;
   int unsigned tables_missing;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   bit          stall_request  = 1'b0;
   bit          stall_taken    = 1'b0;
   int unsigned stall_left     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned words_sent     = 0;
   logic [31:0] cur_size_limit = rdtl_pkg::ROM_SIZE_RESET;
   logic [31:0] image_words [$];

   rom_dma_table_locator_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rom_dma_table_locator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending        (pending),
      .words_seen     (words_seen),
      .images_seen    (images_seen),
      .tables_found   (tables_found),
      .tables_missing (tables_missing)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_access(input logic [2:0] addr, input logic is_write,
                             input logic [31:0] data);
      csr_psel   <= 1'b1;
      csr_pwrite <= is_write;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] size);
      csr_access(ROM_SIZE_ADDR, 1'b1, size);
      csr_access(ROM_SIZE_ADDR, 1'b0, '0);
      cur_size_limit = size;
   endtask

   task automatic send_word(input logic [31:0] word, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_image_words();
      int k;
      for (k = 0; k < image_words.size(); k++)
         send_word(image_words[k], k == image_words.size() - 1);
   endtask

   // Waits until every expected result has been taken, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] filler_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Appends three chained entries whose chain starts at the current byte offset.
   task automatic add_table(input logic [31:0] first_end, input logic [31:0] last_end);
      logic [31:0] pos;
      pos = image_words.size() * 4;
      image_words.push_back('0);
      image_words.push_back(first_end);
      image_words.push_back('0);
      image_words.push_back('0);
      image_words.push_back(first_end);
      image_words.push_back(pos);
      image_words.push_back(first_end);
      image_words.push_back('0);
      image_words.push_back(pos);
      image_words.push_back(last_end);
      image_words.push_back(pos);
      image_words.push_back('0);
   endtask

   task automatic add_random_table();
      logic [31:0] pos;
      logic [31:0] first_end;
      logic [63:0] last_end;
      pos = image_words.size() * 4;
      case ($urandom_range(3))
         0:       first_end = pos;
         1:       first_end = 32'd1;
         default: first_end = $urandom_range(pos, 1);
      endcase
      last_end = {32'd0, pos} + 64'd16 * $urandom_range(8, 1);
      case ($urandom_range(5))
         0: if (cur_size_limit >= pos + 16)
               last_end = {32'd0, pos} + {32'd0, (cur_size_limit - pos) & ~32'hF};
         1: if (cur_size_limit >= pos + 16)
               last_end = {32'd0, pos} + {32'd0, (cur_size_limit - pos) & ~32'hF} + 64'd16;
         2: last_end = last_end + $urandom_range(15, 1);
         default: ;
      endcase
      add_table(first_end, last_end[31:0]);
   endtask

   task automatic send_random_image();
      int unsigned kind;
      int unsigned base;
      kind = $urandom_range(99);
      image_words.delete();
      if (kind < 82) begin
         repeat (4 * ($urandom_range(7) == 0 ? $urandom_range(10, 4) : $urandom_range(3, 1)))
            image_words.push_back(filler_word());
         // A misaligned chain can never sit at a candidate offset.
         if (kind >= 72) repeat ($urandom_range(3, 1)) image_words.push_back(filler_word());
         base = image_words.size();
         add_random_table();
         if (kind >= 55 && kind < 72)
            image_words[base + $urandom_range(11)] ^= 32'd1 << $urandom_range(31);
         if ($urandom_range(3) == 0) begin
            // A second table after the first must stay silent.
            repeat ($urandom_range(2)) image_words.push_back(filler_word());
            while (image_words.size() % 4 != 0) image_words.push_back(filler_word());
            add_random_table();
         end
         repeat ($urandom_range(6)) image_words.push_back(filler_word());
      end else if (kind < 92) begin
         repeat ($urandom_range(40, 1)) image_words.push_back(filler_word());
      end else begin
         repeat ($urandom_range(11, 1)) image_words.push_back(filler_word());
      end
      send_image_words();
   endtask

   initial begin
      int unsigned ph;
      logic [31:0] size;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset size: a write to an unused index is dropped.
      send_idle_pct = 16;
      recv_idle_pct = 75;
      csr_access(SPARE_ADDR, 1'b1, 32'hDEAD_BEEF);
      csr_access(ROM_SIZE_ADDR, 1'b0, '0);
      // Table found on the final word, ending exactly at the top of the ROM.
      image_words.delete();
      image_words.push_back('1);
      image_words.push_back('0);
      image_words.push_back('1);
      image_words.push_back('0);
      add_table(32'd16, rdtl_pkg::ROM_SIZE_RESET);
      send_image_words();
      // Images shorter than three entries.
      image_words.delete();
      image_words.push_back('1);
      image_words.push_back(32'h0000_0010);
      image_words.push_back('0);
      send_image_words();
      image_words.delete();
      image_words.push_back('0);
      send_image_words();

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0:       size = '1;
            1:       size = 32'h0000_0200;
            2:       size = '0;
            3:       size = $urandom;
            4:       size = rdtl_pkg::ROM_SIZE_RESET;
            default: size = 32'h0000_0100;
         endcase
         configure(size);
         case (ph / 2)
            0: begin send_idle_pct = 16; recv_idle_pct = 75; end
            1: begin send_idle_pct = 75; recv_idle_pct = 16; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (ph == 4) stall_request = 1'b1;
         while (words_sent < 20 + (ph + 1) * PHASE_WORDS) send_random_image();
      end
      drain();

      $display("Streamed %0d ROM words in %0d images over %0d rom_size settings.",
               words_seen, images_seen, PHASES + 1);
      $display("%0d tables located, %0d images reported without a table.",
               tables_found, tables_missing);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
